@@ rtl/core/pct_pkg.sv @@
// Types, constants and datapath command codes shared by the polyline thinning block.
package pct_pkg;

  localparam int NODE_DEPTH = 64;
  localparam int NODE_IDX_W = $clog2(NODE_DEPTH);
  localparam int NODE_CNT_W = $clog2(NODE_DEPTH + 1);

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 8;

  localparam logic [CFG_IDX_W-1:0] REG_TOLERANCE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_USE_NODES = 1'd1;

  localparam logic [7:0] TOLERANCE_RESET = 8'd3;

  typedef enum logic [1:0] {
    CMD_VERTEX     = 2'd0,
    CMD_NODE_LOAD  = 2'd1,
    CMD_NODE_CLEAR = 2'd2
  } cmd_t;

  typedef enum logic [1:0] {
    PH_EMPTY   = 2'd0,
    PH_ANCHOR  = 2'd1,
    PH_PENDING = 2'd2
  } phase_t;

  typedef struct packed {
    cmd_t        cmd;
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] point_id;
    logic        end_of_line;
  } in_item_t;

  typedef struct packed {
    logic [31:0] kept_id;
    logic        last_kept;
    logic        removed_any;
  } out_item_t;

  typedef enum logic [3:0] {
    DP_NOP,
    DP_LATCH,
    DP_NODE_LOAD,
    DP_NODE_CLEAR,
    DP_EMIT_FIRST,
    DP_SCAN_START,
    DP_DIFF,
    DP_MUL1,
    DP_MUL2,
    DP_MUL3,
    DP_SUM,
    DP_CMP,
    DP_DROP,
    DP_KEEP,
    DP_FINISH_EOL,
    DP_FINISH_MID
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
  } dp_cmd_t;

  typedef struct packed {
    cmd_t   cmd;
    logic   eol;
    phase_t phase;
    logic   out_free;
    logic   scan_done;
    logic   drop;
  } dp_stat_t;

endpackage

@@ rtl/core/pct_ctrl.sv @@
// Sequencing state machine for the polyline thinning block.
module pct_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  pct_pkg::dp_stat_t stat,
  output pct_pkg::dp_cmd_t  cmd
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_SCAN,
    S_DIFF,
    S_MUL1,
    S_MUL2,
    S_MUL3,
    S_SUM,
    S_CMP,
    S_DECIDE,
    S_FINISH
  } state_t;

  state_t state_r, state_nxt;

  assign in_stall = (state_r != S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd.op    = pct_pkg::DP_NOP;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.op    = pct_pkg::DP_LATCH;
          state_nxt = S_DECODE;
        end
      end
      S_DECODE: begin
        case (stat.cmd)
          pct_pkg::CMD_NODE_LOAD: begin
            cmd.op    = pct_pkg::DP_NODE_LOAD;
            state_nxt = S_IDLE;
          end
          pct_pkg::CMD_NODE_CLEAR: begin
            cmd.op    = pct_pkg::DP_NODE_CLEAR;
            state_nxt = S_IDLE;
          end
          pct_pkg::CMD_VERTEX: begin
            if (stat.phase == pct_pkg::PH_EMPTY) begin
              if (stat.out_free) begin
                cmd.op    = pct_pkg::DP_EMIT_FIRST;
                state_nxt = S_IDLE;
              end
            end else if (stat.phase == pct_pkg::PH_PENDING) begin
              cmd.op    = pct_pkg::DP_SCAN_START;
              state_nxt = S_SCAN;
            end else begin
              state_nxt = S_FINISH;
            end
          end
          default: state_nxt = S_IDLE;  // unused command code
        endcase
      end
      S_SCAN: begin
        if (stat.scan_done) state_nxt = S_DIFF;
      end
      S_DIFF: begin
        cmd.op    = pct_pkg::DP_DIFF;
        state_nxt = S_MUL1;
      end
      S_MUL1: begin
        cmd.op    = pct_pkg::DP_MUL1;
        state_nxt = S_MUL2;
      end
      S_MUL2: begin
        cmd.op    = pct_pkg::DP_MUL2;
        state_nxt = S_MUL3;
      end
      S_MUL3: begin
        cmd.op    = pct_pkg::DP_MUL3;
        state_nxt = S_SUM;
      end
      S_SUM: begin
        cmd.op    = pct_pkg::DP_SUM;
        state_nxt = S_CMP;
      end
      S_CMP: begin
        cmd.op    = pct_pkg::DP_CMP;
        state_nxt = S_DECIDE;
      end
      S_DECIDE: begin
        if (stat.drop) begin
          cmd.op    = pct_pkg::DP_DROP;
          state_nxt = S_FINISH;
        end else if (stat.out_free) begin
          cmd.op    = pct_pkg::DP_KEEP;
          state_nxt = S_FINISH;
        end
      end
      S_FINISH: begin
        if (!stat.eol) begin
          cmd.op    = pct_pkg::DP_FINISH_MID;
          state_nxt = S_IDLE;
        end else if (stat.out_free) begin
          cmd.op    = pct_pkg::DP_FINISH_EOL;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

@@ rtl/core/pct_datapath.sv @@
// Datapath: polyline state, node table with scan, collinearity arithmetic and output register.
module pct_datapath (
  input  logic                             clk,
  input  logic                             rst_n,
  input  pct_pkg::in_item_t                in_data,
  input  logic                             cfg_we,
  input  logic [pct_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [pct_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  pct_pkg::dp_cmd_t                 cmd,
  output pct_pkg::dp_stat_t                stat,
  output logic                             out_valid,
  input  logic                             out_stall,
  output pct_pkg::out_item_t               out_data
);

  function automatic logic [32:0] abs_diff(input logic [31:0] a, input logic [31:0] b);
    logic [32:0] d;
    d = {1'b0, a} - {1'b0, b};
    if (d[32]) abs_diff = {1'b1, b - a};
    else       abs_diff = {1'b0, d[31:0]};
  endfunction

  // configuration
  logic [7:0] tolerance_r;
  logic       use_nodes_r;

  // latched item and polyline state
  pct_pkg::in_item_t in_r;
  logic [31:0]       anchor_x_r, anchor_y_r;
  logic [31:0]       pend_x_r, pend_y_r, pend_id_r;
  pct_pkg::phase_t   phase_r;
  logic              dropped_r;

  // node table
  logic [31:0] node_x_mem [pct_pkg::NODE_DEPTH];
  logic [31:0] node_y_mem [pct_pkg::NODE_DEPTH];
  logic [pct_pkg::NODE_CNT_W-1:0] node_count_r;
  logic [pct_pkg::NODE_CNT_W-1:0] scan_idx_r;
  logic        scan_busy_r, rd_vld_r, hit_r;
  logic [31:0] rd_x_r, rd_y_r;

  // arithmetic
  logic [31:0] dxm_r, dym_r, txm_r, tym_r;
  logic        dxn_r, dyn_r, txn_r, tyn_r;
  logic        horiz_r, vert_r, ty_eq_r, tx_eq_r;
  logic [63:0] m1_r, m2_r, mag_r;
  logic [39:0] rhs_r;
  logic        carry_r, on_r;

  logic [32:0] ad_dx, ad_dy, ad_tx, ad_ty;
  logic [64:0] sum65, dif65;
  logic        opp_sign, out_free, emit;
  pct_pkg::out_item_t out_r;
  logic               out_valid_r;

  assign ad_dx = abs_diff(in_r.x, anchor_x_r);
  assign ad_dy = abs_diff(in_r.y, anchor_y_r);
  assign ad_tx = abs_diff(pend_x_r, anchor_x_r);
  assign ad_ty = abs_diff(pend_y_r, anchor_y_r);

  assign opp_sign = (txn_r ^ dyn_r) != (tyn_r ^ dxn_r);
  assign sum65    = {1'b0, m1_r} + {1'b0, m2_r};
  assign dif65    = {1'b0, m1_r} - {1'b0, m2_r};

  assign out_free = !out_valid_r || !out_stall;
  assign emit     = (cmd.op == pct_pkg::DP_EMIT_FIRST) || (cmd.op == pct_pkg::DP_KEEP) ||
                    (cmd.op == pct_pkg::DP_FINISH_EOL);

  assign stat.cmd       = in_r.cmd;
  assign stat.eol       = in_r.end_of_line;
  assign stat.phase     = phase_r;
  assign stat.out_free  = out_free;
  assign stat.scan_done = !scan_busy_r;
  assign stat.drop      = on_r && !(use_nodes_r && hit_r);

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tolerance_r  <= pct_pkg::TOLERANCE_RESET;
      use_nodes_r  <= 1'b1;
      phase_r      <= pct_pkg::PH_EMPTY;
      dropped_r    <= 1'b0;
      node_count_r <= '0;
      scan_busy_r  <= 1'b0;
      rd_vld_r     <= 1'b0;
      hit_r        <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          pct_pkg::REG_TOLERANCE: tolerance_r <= cfg_data;
          pct_pkg::REG_USE_NODES: use_nodes_r <= cfg_data[0];
        endcase
      end

      if (cmd.op == pct_pkg::DP_NODE_LOAD &&
          node_count_r < pct_pkg::NODE_CNT_W'(pct_pkg::NODE_DEPTH)) begin
        node_count_r <= node_count_r + 1'b1;
      end
      if (cmd.op == pct_pkg::DP_NODE_CLEAR) node_count_r <= '0;

      // node scan: read one entry a cycle, compare on the registered data
      if (cmd.op == pct_pkg::DP_SCAN_START) begin
        scan_busy_r <= 1'b1;
        rd_vld_r    <= 1'b0;
        hit_r       <= 1'b0;
      end else if (scan_busy_r) begin
        rd_vld_r <= (scan_idx_r != node_count_r);
        if (rd_vld_r && rd_x_r == pend_x_r && rd_y_r == pend_y_r) hit_r <= 1'b1;
        if (scan_idx_r == node_count_r && !rd_vld_r) scan_busy_r <= 1'b0;
      end

      case (cmd.op)
        pct_pkg::DP_EMIT_FIRST: begin
          dropped_r <= 1'b0;
          phase_r   <= in_r.end_of_line ? pct_pkg::PH_EMPTY : pct_pkg::PH_ANCHOR;
        end
        pct_pkg::DP_DROP:       dropped_r <= 1'b1;
        pct_pkg::DP_FINISH_EOL: begin
          dropped_r <= 1'b0;
          phase_r   <= pct_pkg::PH_EMPTY;
        end
        pct_pkg::DP_FINISH_MID: phase_r <= pct_pkg::PH_PENDING;
        default: ;
      endcase

      if (emit)            out_valid_r <= 1'b1;
      else if (!out_stall) out_valid_r <= 1'b0;
    end
  end

  // node table storage and read port
  always_ff @(posedge clk) begin
    if (cmd.op == pct_pkg::DP_NODE_LOAD &&
        node_count_r < pct_pkg::NODE_CNT_W'(pct_pkg::NODE_DEPTH)) begin
      node_x_mem[node_count_r[pct_pkg::NODE_IDX_W-1:0]] <= in_r.x;
      node_y_mem[node_count_r[pct_pkg::NODE_IDX_W-1:0]] <= in_r.y;
    end
    rd_x_r <= node_x_mem[scan_idx_r[pct_pkg::NODE_IDX_W-1:0]];
    rd_y_r <= node_y_mem[scan_idx_r[pct_pkg::NODE_IDX_W-1:0]];
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.op == pct_pkg::DP_SCAN_START) begin
      scan_idx_r <= '0;
    end else if (scan_busy_r && scan_idx_r != node_count_r) begin
      scan_idx_r <= scan_idx_r + 1'b1;
    end

    case (cmd.op)
      pct_pkg::DP_LATCH: in_r <= in_data;
      pct_pkg::DP_EMIT_FIRST: begin
        anchor_x_r <= in_r.x;
        anchor_y_r <= in_r.y;
        out_r      <= '{kept_id: in_r.point_id, last_kept: in_r.end_of_line,
                        removed_any: 1'b0};
      end
      pct_pkg::DP_DIFF: begin
        {dxn_r, dxm_r} <= ad_dx;
        {dyn_r, dym_r} <= ad_dy;
        {txn_r, txm_r} <= ad_tx;
        {tyn_r, tym_r} <= ad_ty;
        horiz_r        <= (anchor_y_r == in_r.y);
        vert_r         <= (anchor_x_r == in_r.x);
        ty_eq_r        <= (pend_y_r == anchor_y_r);
        tx_eq_r        <= (pend_x_r == anchor_x_r);
      end
      pct_pkg::DP_MUL1: m1_r  <= 64'(txm_r) * 64'(dym_r);
      pct_pkg::DP_MUL2: m2_r  <= 64'(tym_r) * 64'(dxm_r);
      pct_pkg::DP_MUL3: rhs_r <= 40'(tolerance_r) * 40'(dym_r);
      pct_pkg::DP_SUM: begin
        if (opp_sign) begin
          mag_r   <= sum65[63:0];
          carry_r <= sum65[64];
        end else begin
          mag_r   <= dif65[64] ? (m2_r - m1_r) : dif65[63:0];
          carry_r <= 1'b0;
        end
      end
      pct_pkg::DP_CMP: begin
        // flat or upright reference line (or a point) takes the exact test
        if (horiz_r)     on_r <= ty_eq_r;
        else if (vert_r) on_r <= tx_eq_r;
        else             on_r <= !carry_r && (mag_r <= {24'd0, rhs_r});
      end
      pct_pkg::DP_KEEP: begin
        anchor_x_r <= pend_x_r;
        anchor_y_r <= pend_y_r;
        out_r      <= '{kept_id: pend_id_r, last_kept: 1'b0, removed_any: 1'b0};
      end
      pct_pkg::DP_FINISH_EOL: begin
        out_r <= '{kept_id: in_r.point_id, last_kept: 1'b1, removed_any: dropped_r};
      end
      pct_pkg::DP_FINISH_MID: begin
        pend_x_r  <= in_r.x;
        pend_y_r  <= in_r.y;
        pend_id_r <= in_r.point_id;
      end
      default: ;
    endcase
  end

endmodule

@@ rtl/core/polyline_collinear_thinning.sv @@
// Top level of the polyline thinning block: controller, datapath and checks.
//
// Vertices (cmd 0) stream in one item at a time; the first and last vertex of each polyline
// always come out, a middle vertex comes out only when its successor shows it is off the line
// from the last kept vertex or it matches a node point while node use is enabled. One item
// is in work at a time. A vertex after the second passes through the node table scan (one
// entry per cycle through its single read port), then six steps of the arithmetic unit
// (differences, three multiplies, sum, compare), the keep/drop decision and the finish
// step. Each result waits in the output register, and a further result is held back only
// while that register is full and the output is stalled.
module polyline_collinear_thinning (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  pct_pkg::in_item_t                in_data,
  output logic                             out_valid,
  input  logic                             out_stall,
  output pct_pkg::out_item_t               out_data,
  input  logic                             cfg_we,
  input  logic [pct_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [pct_pkg::CFG_DATA_W-1:0]   cfg_data
);

  pct_pkg::dp_cmd_t  dp_cmd;
  pct_pkg::dp_stat_t dp_stat;

  pct_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (dp_stat),
    .cmd      (dp_cmd)
  );

  pct_datapath u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (dp_cmd),
    .stat      (dp_stat),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  // results are only loaded into a free output register
  a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
    (dp_cmd.op == pct_pkg::DP_EMIT_FIRST || dp_cmd.op == pct_pkg::DP_KEEP ||
     dp_cmd.op == pct_pkg::DP_FINISH_EOL) |-> dp_stat.out_free)
    else $error("item loaded into a full output register");

  // one item in work at a time
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("second item accepted while one is in work");

  // keep/drop decision only after the node scan has finished
  a_scan_first: assert property (@(posedge clk) disable iff (!rst_n)
    (dp_cmd.op == pct_pkg::DP_DROP || dp_cmd.op == pct_pkg::DP_KEEP) |-> dp_stat.scan_done)
    else $error("vertex decided before node scan finished");

  // closing a polyline returns it to the empty phase
  a_eol_phase: assert property (@(posedge clk) disable iff (!rst_n)
    (dp_cmd.op == pct_pkg::DP_FINISH_EOL) |=> (dp_stat.phase == pct_pkg::PH_EMPTY))
    else $error("polyline not closed after its last vertex");

endmodule
